// ----- hdl/rcc_pkg.sv -----
`default_nettype none

package rcc_pkg;

  localparam int PIX_W  = 8;
  localparam int CHANS  = 3;
  localparam int PX_W   = PIX_W * CHANS;
  localparam int TAPS   = 9;
  localparam int ACC_W  = 32;
  localparam int COEF_W = 16;
  localparam int ROW_W  = 16;
  localparam int COL_W  = 10;
  localparam int CFG_W  = 48;
  localparam int CIDX_W = 3;

  localparam logic [CIDX_W-1:0] CFG_COEF_ROW0    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_COEF_ROW1    = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_COEF_ROW2    = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd4;

  typedef logic [PX_W-1:0] px_t;
  typedef logic [TAPS-1:0][PX_W-1:0] win_t;
  typedef logic [CHANS-1:0][ACC_W-1:0] acc_t;

  // Results of one input pixel, in emission order:
  // (r-1,c-1), (r,c-1), (r-1,c), (r,c).
  typedef struct packed {
    logic [3:0]       mask;
    logic [ROW_W-1:0] row_prev;
    logic [ROW_W-1:0] row_cur;
    logic [COL_W-1:0] col_prev;
    logic [COL_W-1:0] col_cur;
    logic             interior;
    logic [3:0]       last;
  } meta_t;

endpackage

`default_nettype wire

// ----- hdl/rcc_ram.sv -----
`default_nettype none

module rcc_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/rcc_cell.sv -----
`default_nettype none

module rcc_cell #(
  parameter int TAP  = 0,
  parameter int FRAC = 8
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       en_i,
  input  wire logic                       valid_i,
  input  wire rcc_pkg::win_t              win_i,
  input  wire rcc_pkg::acc_t              acc_i,
  input  wire rcc_pkg::meta_t             meta_i,
  input  wire logic signed [15:0]         coef_i,
  output logic                            valid_o,
  output rcc_pkg::win_t                   win_o,
  output rcc_pkg::acc_t                   acc_o,
  output rcc_pkg::meta_t                  meta_o
);
  import rcc_pkg::*;

  localparam int SW = ACC_W + FRAC + 1;

  logic  valid_q;
  win_t  win_q;
  acc_t  acc_q, acc_d;
  meta_t meta_q;

  // One multiply-add step per channel, with the sum truncated toward zero.
  always_comb begin
    logic [PIX_W-1:0]         pix;
    logic signed [COEF_W+PIX_W:0] prod;
    logic signed [SW-1:0]     s;
    logic signed [SW-1:0]     adj;
    logic signed [SW-1:0]     q;
    for (int ch = 0; ch < CHANS; ch++) begin
      pix  = win_i[TAP][PIX_W*ch +: PIX_W];
      prod = coef_i * $signed({1'b0, pix});
      s    = (SW'($signed(acc_i[ch])) <<< FRAC) + SW'(prod);
      adj  = s + (s[SW-1] ? SW'((1 << FRAC) - 1) : SW'(0));
      q    = adj >>> FRAC;
      acc_d[ch] = q[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      win_q  <= win_i;
      acc_q  <= acc_d;
      meta_q <= meta_i;
    end
  end

  assign valid_o = valid_q;
  assign win_o   = win_q;
  assign acc_o   = acc_q;
  assign meta_o  = meta_q;

endmodule

`default_nettype wire

// ----- hdl/rgb_conv3x3_clamp.sv -----
`default_nettype none

// Channel  | Direction | Handshake             | Payload
// in       | input     | in_valid_i/in_ready_o | in_ch0_i, in_ch1_i, in_ch2_i
// out      | output    | out_valid_o/out_ready_i | out_row_o, out_col_o, out_ch*_o, frame_done_o
// cfg      | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One pixel is accepted per cycle while the chain is not stalled; a transaction passes the
// front stage, the nine-cell multiply-add chain and the result bundle register. The single
// output port sets the rate: a pixel that yields several results holds the input until its extra ones are issued.
// Reset clears counters, window and all valid flags and loads the default configuration; line stores are not cleared.
// Once a valid result waits in the last cell, a stalled output freezes the whole chain, and the input stalls with it.

module rgb_conv3x3_clamp #(
  parameter int MAX_WIDTH      = 1024,
  parameter int COEF_FRAC_BITS = 8
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [rcc_pkg::PIX_W-1:0]   in_ch0_i,
  input  wire logic [rcc_pkg::PIX_W-1:0]   in_ch1_i,
  input  wire logic [rcc_pkg::PIX_W-1:0]   in_ch2_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [rcc_pkg::ROW_W-1:0]        out_row_o,
  output logic [rcc_pkg::COL_W-1:0]        out_col_o,
  output logic [rcc_pkg::PIX_W-1:0]        out_ch0_o,
  output logic [rcc_pkg::PIX_W-1:0]        out_ch1_o,
  output logic [rcc_pkg::PIX_W-1:0]        out_ch2_o,
  output logic                             frame_done_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [rcc_pkg::CIDX_W-1:0]  cfg_index_i,
  input  wire logic [rcc_pkg::CFG_W-1:0]   cfg_data_i
);
  import rcc_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [2:0][CFG_W-1:0] coef_q;
  logic [10:0]           width_q;
  logic [ROW_W-1:0]      height_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= '0;
      coef_q[1] <= 48'h0000_0100_0000;
      coef_q[2] <= '0;
      width_q   <= 11'd640;
      height_q  <= 16'd480;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COEF_ROW0:    coef_q[0] <= cfg_data_i;
        CFG_COEF_ROW1:    coef_q[1] <= cfg_data_i;
        CFG_COEF_ROW2:    coef_q[2] <= cfg_data_i;
        CFG_IMAGE_WIDTH:  width_q   <= cfg_data_i[10:0];
        CFG_IMAGE_HEIGHT: height_q  <= cfg_data_i[ROW_W-1:0];
        default: ;
      endcase
    end
  end

  logic [WW-1:0]    w_lim, wm1, c_ext, cm1_ext;
  logic [ROW_W-1:0] hm1;

  always_comb begin
    if (width_q == '0) begin
      w_lim = WW'(1);
    end else if (int'(width_q) > MAX_WIDTH) begin
      w_lim = WW'(MAX_WIDTH);
    end else begin
      w_lim = WW'(width_q);
    end
    wm1 = w_lim - 1'b1;
    hm1 = (height_q == '0) ? '0 : height_q - 1'b1;
  end

  logic [CW-1:0]    col_q, cm1;
  logic [ROW_W-1:0] row_q, rm1;
  logic             en, in_acc;
  meta_t            meta_in;

  assign in_ready_o = en;
  assign in_acc     = in_valid_i && en;
  assign cm1        = col_q - 1'b1;
  assign rm1        = row_q - 1'b1;
  assign c_ext      = WW'(col_q);
  assign cm1_ext    = WW'(cm1);

  always_comb begin
    logic cprev, clast, rprev, rlast;
    cprev = col_q != '0;
    clast = c_ext == wm1;
    rprev = row_q != '0;
    rlast = row_q == hm1;
    meta_in.mask     = {clast & rlast, clast & rprev, cprev & rlast, cprev & rprev};
    meta_in.row_prev = rm1;
    meta_in.row_cur  = row_q;
    meta_in.col_prev = COL_W'(cm1);
    meta_in.col_cur  = COL_W'(col_q);
    meta_in.interior = (row_q >= 16'd2) && (row_q <= hm1)
                       && (col_q >= CW'(2)) && (c_ext <= wm1);
    meta_in.last[0]  = (rm1 == hm1) && (cm1_ext == wm1);
    meta_in.last[1]  = (row_q == hm1) && (cm1_ext == wm1);
    meta_in.last[2]  = (rm1 == hm1) && (c_ext == wm1);
    meta_in.last[3]  = (row_q == hm1) && (c_ext == wm1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      if (c_ext >= wm1) begin
        col_q <= '0;
        row_q <= (row_q >= hm1) ? '0 : row_q + 1'b1;
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // Front stage: pixel waits here for its line store reads.
  logic          v0_q;
  px_t           px0_q;
  logic [CW-1:0] addr0_q;
  meta_t         meta0_q;
  logic          adv0;
  px_t           up_rd, lo_rd, up_eff, lo_eff;
  logic          fwd_q;
  px_t           fwd_up_q, fwd_lo_q;
  win_t          win_q, win_d;

  assign adv0   = en && v0_q;
  assign up_eff = fwd_q ? fwd_up_q : up_rd;
  assign lo_eff = fwd_q ? fwd_lo_q : lo_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q  <= 1'b0;
      fwd_q <= 1'b0;
      win_q <= '0;
    end else begin
      if (en) begin
        v0_q <= in_valid_i;
      end
      if (in_acc) begin
        fwd_q <= adv0 && (addr0_q == col_q);
      end
      if (adv0) begin
        win_q <= win_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      px0_q    <= {in_ch2_i, in_ch1_i, in_ch0_i};
      addr0_q  <= col_q;
      meta0_q  <= meta_in;
      fwd_up_q <= lo_eff;
      fwd_lo_q <= px0_q;
    end
  end

  always_comb begin
    win_d = win_q;
    for (int a = 0; a < 3; a++) begin
      win_d[a*3+0] = win_q[a*3+1];
      win_d[a*3+1] = win_q[a*3+2];
    end
    win_d[2] = up_eff;
    win_d[5] = lo_eff;
    win_d[8] = px0_q;
  end

  rcc_ram #(.WIDTH(PX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
    .clk_i   (clk_i),
    .we_i    (adv0),
    .waddr_i (addr0_q),
    .wdata_i (lo_eff),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (up_rd)
  );

  rcc_ram #(.WIDTH(PX_W), .DEPTH(MAX_WIDTH)) u_line_lower (
    .clk_i   (clk_i),
    .we_i    (adv0),
    .waddr_i (addr0_q),
    .wdata_i (px0_q),
    .re_i    (in_acc),
    .raddr_i (col_q),
    .rdata_o (lo_rd)
  );

  logic  [TAPS:0] cv;
  win_t  [TAPS:0] cwin;
  acc_t  [TAPS:0] cacc;
  meta_t [TAPS:0] cmeta;

  assign cv[0]    = v0_q;
  assign cwin[0]  = win_d;
  assign cacc[0]  = '0;
  assign cmeta[0] = meta0_q;

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    rcc_cell #(.TAP(k), .FRAC(COEF_FRAC_BITS)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cv[k]),
      .win_i   (cwin[k]),
      .acc_i   (cacc[k]),
      .meta_i  (cmeta[k]),
      .coef_i  ($signed(coef_q[k/3][16*(k%3) +: 16])),
      .valid_o (cv[k+1]),
      .win_o   (cwin[k+1]),
      .acc_o   (cacc[k+1]),
      .meta_o  (cmeta[k+1])
    );
  end

  // Result bundle: up to four results of one pixel, issued lowest bit first.
  logic [3:0] bmask_q;
  meta_t      bmeta_q;
  px_t        bval_q, clamp;
  logic       out_acc, load_ok;

  always_comb begin
    logic signed [ACC_W-1:0] a;
    for (int ch = 0; ch < CHANS; ch++) begin
      a = $signed(cacc[TAPS][ch]);
      if (a > 32'sd255) begin
        clamp[PIX_W*ch +: PIX_W] = 8'd255;
      end else if (a < 32'sd0) begin
        clamp[PIX_W*ch +: PIX_W] = 8'd0;
      end else begin
        clamp[PIX_W*ch +: PIX_W] = a[PIX_W-1:0];
      end
    end
  end

  assign out_valid_o = bmask_q != '0;
  assign out_acc     = out_valid_o && out_ready_i;
  assign load_ok     = (bmask_q == '0) || ($onehot(bmask_q) && out_ready_i);
  assign en          = !cv[TAPS] || load_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bmask_q <= '0;
    end else if (cv[TAPS] && load_ok) begin
      bmask_q <= cmeta[TAPS].mask;
    end else if (out_acc) begin
      bmask_q <= bmask_q & (bmask_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cv[TAPS] && load_ok) begin
      bmeta_q <= cmeta[TAPS];
      bval_q  <= cmeta[TAPS].interior ? clamp : '0;
    end
  end

  always_comb begin
    px_t v;
    v = '0;
    if (bmask_q[0]) begin
      out_row_o    = bmeta_q.row_prev;
      out_col_o    = bmeta_q.col_prev;
      v            = bval_q;
      frame_done_o = bmeta_q.last[0];
    end else if (bmask_q[1]) begin
      out_row_o    = bmeta_q.row_cur;
      out_col_o    = bmeta_q.col_prev;
      frame_done_o = bmeta_q.last[1];
    end else if (bmask_q[2]) begin
      out_row_o    = bmeta_q.row_prev;
      out_col_o    = bmeta_q.col_cur;
      frame_done_o = bmeta_q.last[2];
    end else begin
      out_row_o    = bmeta_q.row_cur;
      out_col_o    = bmeta_q.col_cur;
      frame_done_o = bmeta_q.last[3];
    end
    out_ch0_o = v[7:0];
    out_ch1_o = v[15:8];
    out_ch2_o = v[23:16];
  end

endmodule

`default_nettype wire

// ----- hdl/rcc_checker.sv -----
`default_nettype none

module rcc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_o,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [15:0] out_row_o,
  input wire logic [9:0]  out_col_o,
  input wire logic [7:0]  out_ch0_o,
  input wire logic [7:0]  out_ch1_o,
  input wire logic [7:0]  out_ch2_o,
  input wire logic        frame_done_o
);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_row_o)
      && $stable(out_col_o) && $stable(out_ch0_o) && $stable(out_ch1_o)
      && $stable(out_ch2_o) && $stable(frame_done_o))
    else $error("result changed while stalled");

  // Pixels in the top row or left column are border pixels.
  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_row_o == 16'd0 || out_col_o == 10'd0)
      |-> out_ch0_o == 8'd0 && out_ch1_o == 8'd0 && out_ch2_o == 8'd0)
    else $error("nonzero border result");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // With nothing pending at the output, the input is never held off.
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled without output pressure");

endmodule

bind rgb_conv3x3_clamp rcc_checker u_rcc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .out_row_o    (out_row_o),
  .out_col_o    (out_col_o),
  .out_ch0_o    (out_ch0_o),
  .out_ch1_o    (out_ch1_o),
  .out_ch2_o    (out_ch2_o),
  .frame_done_o (frame_done_o)
);

`default_nettype wire

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import rcc_pkg::*;

  localparam int LS_DEPTH  = 1024;
  localparam int DRAIN_CYC = 24;

  typedef enum int { PAT_RANDOM, PAT_CHECKER, PAT_WHITE, PAT_BLACK } pattern_e;

  typedef struct {
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [PIX_W-1:0] ch0;
    logic [PIX_W-1:0] ch1;
    logic [PIX_W-1:0] ch2;
    logic             done;
  } filt_px_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [PIX_W-1:0]  in_ch0_i = '0;
  logic [PIX_W-1:0]  in_ch1_i = '0;
  logic [PIX_W-1:0]  in_ch2_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ROW_W-1:0]  out_row_o;
  logic [COL_W-1:0]  out_col_o;
  logic [PIX_W-1:0]  out_ch0_o;
  logic [PIX_W-1:0]  out_ch1_o;
  logic [PIX_W-1:0]  out_ch2_o;
  logic              frame_done_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [CIDX_W-1:0] cfg_index_i = CFG_COEF_ROW0;
  logic [CFG_W-1:0]  cfg_data_i = '0;

  rgb_conv3x3_clamp dut (.*);

  always #1 clk_i = ~clk_i;

  // Mirror of the filter state.
  logic [CFG_W-1:0] coef_m[3];
  logic [10:0]      width_m;
  logic [15:0]      height_m;
  logic [PX_W-1:0]  upper_ls[LS_DEPTH];
  logic [PX_W-1:0]  lower_ls[LS_DEPTH];
  logic [PX_W-1:0]  win_m[9];
  int unsigned      row_m, col_m;

  filt_px_t expected_px[$];
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit long_hold = 0;
  int hold_cnt = 0;
  int mismatches = 0;
  int results_seen = 0;
  int pixels_sent = 0;
  int frames_sent = 0;

  function automatic logic [PX_W-1:0] filter_window();
    logic [PX_W-1:0] res;
    longint acc, prod;
    logic [COEF_W-1:0] raw;
    res = '0;
    for (int ch = 0; ch < 3; ch++) begin
      acc = 0;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          raw = coef_m[a][16*b +: 16];
          prod = longint'($signed(raw)) * longint'(win_m[a*3+b][8*ch +: 8]);
          acc = (acc * 256 + prod) / 256;
        end
      end
      if (acc > 255) acc = 255;
      if (acc < 0) acc = 0;
      res[8*ch +: 8] = acc[7:0];
    end
    return res;
  endfunction

  function automatic void predict_pixel(logic [PX_W-1:0] px);
    int unsigned w, h, r, c, ci, nc, nr, rr, cc;
    int unsigned cols[2], rows[2];
    logic [PX_W-1:0] v;
    filt_px_t e;
    w = width_m;
    h = height_m;
    if (w < 1) w = 1;
    if (w > LS_DEPTH) w = LS_DEPTH;
    if (h < 1) h = 1;
    r = row_m;
    c = col_m;
    ci = c % LS_DEPTH;
    for (int a = 0; a < 3; a++) begin
      win_m[a*3] = win_m[a*3+1];
      win_m[a*3+1] = win_m[a*3+2];
    end
    win_m[2] = upper_ls[ci];
    win_m[5] = lower_ls[ci];
    win_m[8] = px;
    upper_ls[ci] = lower_ls[ci];
    lower_ls[ci] = px;
    nc = 0;
    nr = 0;
    if (c >= 1) begin
      cols[nc] = c - 1;
      nc++;
    end
    if (c == w - 1) begin
      cols[nc] = c;
      nc++;
    end
    if (r >= 1) begin
      rows[nr] = r - 1;
      nr++;
    end
    if (r == h - 1) begin
      rows[nr] = r;
      nr++;
    end
    for (int i = 0; i < nc; i++) begin
      for (int k = 0; k < nr; k++) begin
        rr = rows[k];
        cc = cols[i];
        v = (rr >= 1 && rr + 2 <= h && cc >= 1 && cc + 2 <= w) ? filter_window() : '0;
        e.row = rr[15:0];
        e.col = cc[9:0];
        e.ch0 = v[7:0];
        e.ch1 = v[15:8];
        e.ch2 = v[23:16];
        e.done = (rr == h - 1 && cc == w - 1);
        expected_px.push_back(e);
      end
    end
    if (c >= w - 1) begin
      col_m = 0;
      row_m = (r >= h - 1) ? 0 : r + 1;
    end else begin
      col_m = c + 1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_cnt <= 0;
    end else if (long_hold && hold_cnt < 300) begin
      out_ready_i <= 1'b0;
      hold_cnt <= hold_cnt + 1;
    end else begin
      if (!long_hold) hold_cnt <= 0;
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    filt_px_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_px.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result row %0d col %0d", out_row_o, out_col_o);
      end else begin
        e = expected_px.pop_front();
        if (out_row_o !== e.row || out_col_o !== e.col || out_ch0_o !== e.ch0 ||
            out_ch1_o !== e.ch1 || out_ch2_o !== e.ch2 || frame_done_o !== e.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp r%0d c%0d %h %h %h d%0b got r%0d c%0d %h %h %h d%0b",
                     e.row, e.col, e.ch0, e.ch1, e.ch2, e.done, out_row_o, out_col_o,
                     out_ch0_o, out_ch1_o, out_ch2_o, frame_done_o);
        end
      end
    end
  end

  task automatic send_px(input logic [PIX_W-1:0] a, b, c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_ch0_i <= a;
    in_ch1_i <= b;
    in_ch2_i <= c;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predict_pixel({c, b, a});
    pixels_sent++;
  endtask

  task automatic send_random_px();
    send_px(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
            PIX_W'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_px.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_COEF_ROW0: coef_m[0] = data;
      CFG_COEF_ROW1: coef_m[1] = data;
      CFG_COEF_ROW2: coef_m[2] = data;
      CFG_IMAGE_WIDTH: width_m = data[10:0];
      CFG_IMAGE_HEIGHT: height_m = data[15:0];
      default: ;
    endcase
  endtask

  task automatic set_kernel(input logic [CFG_W-1:0] k0, k1, k2);
    write_reg(CFG_COEF_ROW0, k0);
    write_reg(CFG_COEF_ROW1, k1);
    write_reg(CFG_COEF_ROW2, k2);
  endtask

  task automatic random_kernel();
    logic [CFG_W-1:0] k[3];
    for (int i = 0; i < 3; i++) begin
      k[i] = CFG_W'({$urandom(), $urandom()});
      // Keep most kernels small so that results do not all clamp.
      if ($urandom_range(2) != 0)
        for (int j = 0; j < 3; j++)
          k[i][16*j +: 16] = 16'($signed(16'($urandom_range(0, 1023))) - 16'sd512);
    end
    set_kernel(k[0], k[1], k[2]);
  endtask

  // Sends one whole image at the given register values, so sizes only change
  // between images.
  task automatic send_frame(input int wreg, input int hreg, input pattern_e pat);
    int w, h;
    logic [PIX_W-1:0] v;
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(wreg));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(hreg));
    w = (wreg < 1) ? 1 : (wreg > LS_DEPTH) ? LS_DEPTH : wreg;
    h = (hreg < 1) ? 1 : hreg;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (pat)
          PAT_CHECKER: v = ((r + c) % 2) ? 8'hFF : 8'h00;
          PAT_WHITE:   v = 8'hFF;
          PAT_BLACK:   v = 8'h00;
          default:     v = PIX_W'($urandom_range(255));
        endcase
        if (pat == PAT_RANDOM) send_px(v, PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)));
        else send_px(v, ~v, v);
      end
    end
    frames_sent++;
    wait_drained();
  endtask

  task automatic test_directed();
    send_frame(3, 3, PAT_RANDOM);
    send_frame(4, 3, PAT_CHECKER);
    set_kernel({3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
    send_frame(3, 4, PAT_WHITE);
    set_kernel({3{16'h8000}}, {3{16'h8000}}, {3{16'h8000}});
    send_frame(3, 3, PAT_WHITE);
    // Negative fractional taps exercise truncation toward zero after each add.
    set_kernel({16'hFF80, 16'h0080, 16'hFFC1}, {16'h0101, 16'hFE7F, 16'h00C3},
               {16'h0040, 16'hFFFF, 16'h0001});
    send_frame(5, 4, PAT_CHECKER);
    send_frame(3, 3, PAT_BLACK);
  endtask

  task automatic test_size_extremes();
    random_kernel();
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(16'hFFFF));
    send_frame(0, 3, PAT_RANDOM);
    send_frame(5, 0, PAT_RANDOM);
    send_frame(2, 2, PAT_RANDOM);
  endtask

  task automatic test_random_frames(input int snd, input int stl);
    int target;
    send_idle_pct = snd;
    stall_pct = stl;
    target = pixels_sent + 30;
    while (pixels_sent < target) begin
      random_kernel();
      send_frame($urandom_range(3, 9), $urandom_range(3, 6), PAT_RANDOM);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    random_kernel();
    write_reg(CFG_IMAGE_WIDTH, CFG_W'(8));
    write_reg(CFG_IMAGE_HEIGHT, CFG_W'(6));
    long_hold = 1;
    for (int i = 0; i < 24; i++) send_random_px();
    long_hold = 0;
    // Sender stops mid-image until everything owed so far has come out.
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_px.size() != 0) @(posedge clk_i);
    for (int i = 0; i < 24; i++) send_random_px();
    frames_sent++;
    wait_drained();
  endtask

  initial begin
    coef_m[0] = '0;
    coef_m[1] = 48'h0000_0100_0000;
    coef_m[2] = '0;
    width_m = 11'd640;
    height_m = 16'd480;
    for (int i = 0; i < LS_DEPTH; i++) begin
      upper_ls[i] = '0;
      lower_ls[i] = '0;
    end
    for (int i = 0; i < 9; i++) win_m[i] = '0;
    row_m = 0;
    col_m = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_size_extremes();
    test_random_frames(0, 0);
    test_random_frames(73, 0);
    test_random_frames(0, 73);
    test_random_frames(18, 18);
    test_backpressure();
    $display("Sent %0d pixels in %0d images and checked %0d filtered pixels,", pixels_sent,
             frames_sent, results_seen);
    $display("covering size extremes, clamping kernels and several idle and stall mixes.");
    if (mismatches == 0 && expected_px.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_px.size());
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("timeout with %0d results outstanding", expected_px.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
